@@ hdl/lcdnw_pkg.sv @@
// shared types and constants for the character-LCD write sequencer
package lcdnw_pkg;

  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_CHAR = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned DIGITS   = 10;
  localparam int unsigned BCD_W    = 4 * DIGITS;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;
  localparam logic [7:0]  DEC_BASE   = 8'd10;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic               is_num;
    logic               rs;
    logic [VALUE_W-1:0] data;
  } q_entry_t;

endpackage

@@ hdl/lcdnw_front.sv @@
// front end: classifies requests and pushes them into the queue
module lcdnw_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_mode,
  input  logic [31:0]           in_value,
  input  logic                  q_full,
  output logic                  q_push,
  output lcdnw_pkg::q_entry_t   q_entry
);
  import lcdnw_pkg::*;

  logic [7:0] ch;

  assign in_stall = q_full;
  // mode 3 is taken and dropped
  assign q_push   = in_valid && !q_full && (in_mode != MODE_NONE);
  assign ch       = in_value[7:0];

  always_comb begin
    q_entry = '0;
    unique case (in_mode)
      MODE_CMD: begin
        q_entry.rs        = 1'b0;
        q_entry.data[7:0] = ch;
      end
      MODE_CHAR: begin
        q_entry.rs        = 1'b1;
        q_entry.data[7:0] = (ch < DEC_BASE) ? (ch + ASCII_ZERO) : ch;
      end
      MODE_NUM: begin
        q_entry.is_num = 1'b1;
        q_entry.rs     = 1'b1;
        q_entry.data   = in_value;
      end
      default: q_entry = '0;
    endcase
  end

endmodule

@@ hdl/lcdnw_queue.sv @@
// short request queue between front end and sequencer
module lcdnw_queue #(
  parameter int unsigned DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lcdnw_pkg::q_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output lcdnw_pkg::q_entry_t pop_entry,
  output logic                empty
);
  import lcdnw_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  q_entry_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");

  a_full_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (wr_ptr_r == rd_ptr_r))
    else $error("full queue with unequal pointers");

endmodule

@@ hdl/lcdnw_back.sv @@
// back end: binary to decimal conversion and bus transfer sequencing
module lcdnw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                four_bit,
  input  logic                q_empty,
  input  lcdnw_pkg::q_entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_register_select,
  output logic [7:0]          out_bus_value,
  output logic                out_last
);
  import lcdnw_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SKIP  = 3'd2;
  localparam logic [2:0] S_DIGIT = 3'd3;
  localparam logic [2:0] S_SEND  = 3'd4;

  localparam int unsigned CNT_W = $clog2(VALUE_W);
  localparam int unsigned DIG_W = $clog2(DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

  logic [2:0]         state_r, state_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt, bcd_adj;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIG_W-1:0]   dig_left_r, dig_left_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               rs_r, rs_nxt;
  logic               last_byte_r, last_byte_nxt;
  logic               half_r, half_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_rs_r, out_rs_nxt;
  logic [7:0]         out_bus_r, out_bus_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_free, emit, byte_done;
  logic [3:0]         top_digit;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = (state_r == S_SEND) && out_free;
  assign byte_done = !four_bit || half_r;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    bcd_adj = bcd_r;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    dig_left_nxt  = dig_left_r;
    byte_nxt      = byte_r;
    rs_nxt        = rs_r;
    last_byte_nxt = last_byte_r;
    half_nxt      = half_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rs_nxt    = out_rs_r;
    out_bus_nxt   = out_bus_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          rs_nxt   = q_entry.rs;
          half_nxt = 1'b0;
          if (q_entry.is_num && (q_entry.data != '0)) begin
            bin_nxt   = q_entry.data;
            bcd_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_CONV;
          end else begin
            // zero prints as a single digit
            byte_nxt      = q_entry.is_num ? ASCII_ZERO : q_entry.data[7:0];
            last_byte_nxt = 1'b1;
            state_nxt     = S_SEND;
          end
        end
      end
      S_CONV: begin
        {bcd_nxt, bin_nxt} = {bcd_adj, bin_r} << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          dig_left_nxt = DIG_W'(DIGITS);
          state_nxt    = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zero digits, value is known nonzero here
        if (top_digit == 4'd0) begin
          bcd_nxt      = bcd_r << 4;
          dig_left_nxt = dig_left_r - 1'b1;
        end else begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        byte_nxt      = ASCII_ZERO | {4'd0, top_digit};
        last_byte_nxt = (dig_left_r == DIG_W'(1));
        bcd_nxt       = bcd_r << 4;
        dig_left_nxt  = dig_left_r - 1'b1;
        half_nxt      = 1'b0;
        state_nxt     = S_SEND;
      end
      S_SEND: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_rs_nxt    = rs_r;
          out_last_nxt  = last_byte_r && byte_done;
          if (!four_bit) begin
            out_bus_nxt = byte_r;
          end else if (!half_r) begin
            out_bus_nxt = {byte_r[7:4], 4'd0};
          end else begin
            out_bus_nxt = {byte_r[3:0], 4'd0};
          end
          half_nxt = !byte_done;
          if (byte_done) begin
            state_nxt = last_byte_r ? S_IDLE : S_DIGIT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r       <= bin_nxt;
    bcd_r       <= bcd_nxt;
    cnt_r       <= cnt_nxt;
    dig_left_r  <= dig_left_nxt;
    byte_r      <= byte_nxt;
    rs_r        <= rs_nxt;
    last_byte_r <= last_byte_nxt;
    out_rs_r    <= out_rs_nxt;
    out_bus_r   <= out_bus_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_register_select = out_rs_r;
  assign out_bus_value       = out_bus_r;
  assign out_last            = out_last_r;

  a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV && cnt_r == CNT_LAST) |=> (state_r == S_SKIP))
    else $error("conversion did not end after all bits");

  a_skip_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SKIP) |-> (dig_left_r != '0))
    else $error("zero skip ran past the last digit");

  a_digit_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIGIT) |-> (top_digit <= 4'd9))
    else $error("converted digit out of decimal range");

  a_nibble_low: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && four_bit) |=> (out_bus_r[3:0] == 4'd0))
    else $error("nibble transfer with low bits set");

endmodule

@@ hdl/lcd_char_number_writer_core.sv @@
// top level of the character-LCD write sequencer
//
//  port group | direction | payload                                      | flow control
//  in_        | request   | in_mode, in_value                            | in_valid / in_stall
//  out_       | transfer  | out_register_select, out_bus_value, out_last | out_valid / out_stall
//  cfg_       | write     | cfg_wr_data (four-bit bus)                   | cfg_wr_en
//
// a command or character goes out as one bus transfer, or two on the four-bit bus
// a number is converted from binary to decimal by shifting all 32 value bits,
// then leading zero digits are dropped and each printed digit goes out as 1
// or 2 bus transfers (up to 10 digits)
// reset (rst_n low, synchronous) empties the queue and selects the four-bit bus
// out_stall holds the transfer register; in_stall rises when the queue is full
module lcd_char_number_writer_core #(
  parameter int unsigned QUEUE_DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_register_select,
  output logic [7:0]  out_bus_value,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);
  import lcdnw_pkg::*;

  logic     four_bit_r, four_bit_nxt;
  logic     q_full, q_empty, q_push, q_pop;
  q_entry_t push_entry, pop_entry;

  assign four_bit_nxt = cfg_wr_en ? cfg_wr_data : four_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_r <= 1'b1;
    end else begin
      four_bit_r <= four_bit_nxt;
    end
  end

  lcdnw_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  lcdnw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  lcdnw_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .four_bit            (four_bit_r),
    .q_empty             (q_empty),
    .q_entry             (pop_entry),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_register_select (out_register_select),
    .out_bus_value       (out_bus_value),
    .out_last            (out_last)
  );

endmodule

@@ test/tb_lcd_char_number_writer_core.sv @@
// testbench for the character-LCD write sequencer: predicts and checks every bus transfer
`timescale 1ns / 1ps

module tb_lcd_char_number_writer_core;
  import lcdnw_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_WAIT   = 17;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 300;

  class lcd_transfer_sb;
    bit four_bit;
    logic [9:0] expected_transfers[$];  // {register_select, bus_value, last}
    int mismatches;
    int checked;
    int requests[4];

    function new();
      four_bit = 1'b1;
      mismatches = 0;
      checked = 0;
      foreach (requests[i]) requests[i] = 0;
    endfunction

    function int pending();
      return expected_transfers.size();
    endfunction

    // turns one accepted request into the transfers it should produce
    function void predict_request(logic [1:0] mode, logic [31:0] value);
      logic [7:0] text[$];
      logic [31:0] rest;
      logic [7:0] c;
      bit rs;
      bit fin;
      rs = 1'b1;
      requests[mode]++;
      case (mode)
        MODE_CMD: begin
          rs = 1'b0;
          text.push_back(value[7:0]);
        end
        MODE_CHAR: begin
          c = value[7:0];
          if (c < 8'd10) c = c + ASCII_ZERO;
          text.push_back(c);
        end
        MODE_NUM: begin
          rest = value;
          do begin
            c = 8'(rest % 32'd10);
            text.push_front(ASCII_ZERO + c);
            rest = rest / 32'd10;
          end while (rest != 0);
        end
        default: ;
      endcase
      foreach (text[i]) begin
        fin = (i == text.size() - 1);
        if (four_bit) begin
          expected_transfers.push_back({rs, text[i][7:4], 4'h0, 1'b0});
          expected_transfers.push_back({rs, text[i][3:0], 4'h0, fin});
        end else begin
          expected_transfers.push_back({rs, text[i], fin});
        end
      end
    endfunction

    function void check_transfer(logic rs, logic [7:0] bus, logic last);
      logic [9:0] want;
      checked++;
      if (expected_transfers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected transfer rs=%b bus=%h last=%b", $realtime, rs, bus, last);
        return;
      end
      want = expected_transfers.pop_front();
      if (rs !== want[9] || bus !== want[8:1] || last !== want[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: transfer mismatch: expected rs=%b bus=%h last=%b, got rs=%b bus=%h last=%b",
                   $realtime, want[9], want[8:1], want[0], rs, bus, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_NONE;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic        out_register_select;
  logic [7:0]  out_bus_value;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b1;

  lcd_transfer_sb sb;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold_cycles = 0;
  int input_held_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lcd_char_number_writer_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_register_select (out_register_select),
    .out_bus_value       (out_bus_value),
    .out_last            (out_last),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  function automatic int draw_wait(bit en);
    return en ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  // numbers of every length, from zero up to full 32-bit values, each length about equally likely
  function automatic logic [31:0] draw_number();
    int k;
    logic [31:0] lo;
    k = $urandom_range(0, 10);
    if (k == 0) return 32'd0;
    if (k == 10) return $urandom();
    lo = 1;
    repeat (k - 1) lo = lo * 10;
    return $urandom_range(lo * 10 - 1, lo);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic [1:0] mode, input logic [31:0] value);
    int gap;
    gap = draw_wait(tx_idle_en);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.predict_request(mode, value);
    @(negedge clk);
  endtask

  // wait for the block to go quiet, then write the bus width
  task automatic set_bus_width(input bit four);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= four;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.four_bit = four;
  endtask

  task automatic run_random(input int count, input bit pressure);
    int real_items;
    int n;
    int r;
    logic [1:0] mode;
    logic [31:0] value;
    real_items = 0;
    n = 0;
    if (pressure) begin
      tx_idle_en = 1'b0;
      rx_hold_cycles = HOLD_CYCLES;
    end
    while (real_items < count) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        mode = MODE_CMD;
        value = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 255);
      end else if (r < 45) begin
        mode = MODE_CHAR;
        case ($urandom_range(0, 2))
          0:       value = $urandom_range(0, 9);
          1:       value = $urandom_range(0, 255);
          default: value = $urandom();
        endcase
      end else if (r < 93) begin
        mode = MODE_NUM;
        value = draw_number();
      end else begin
        mode = MODE_NONE;
        value = $urandom();
      end
      send_request(mode, value);
      if (mode != MODE_NONE) real_items++;
      n++;
      if (n % 25 == 24 && !(pressure && n < 40))
        tx_idle_en = ($urandom_range(0, 2) != 0);
    end
    in_valid <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off when asked
  initial begin : transfer_sink
    int wait_cycles;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      wait_cycles = draw_wait(rx_idle_en) + rx_hold_cycles;
      rx_hold_cycles = 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_transfer(out_register_select, out_bus_value, out_last);
      taken++;
      if (taken % 25 == 0) rx_idle_en = ($urandom_range(0, 2) != 0);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (in_valid === 1'b1 && in_stall === 1'b1) input_held_cycles++;
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no request or transfer moved for %0d cycles", IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_bus_width(1'b1);
    // directed: field extremes, digit mapping edges, wide values, ignored mode
    send_request(MODE_CMD,  32'h0000_0000);
    send_request(MODE_CMD,  32'h0000_00FF);
    send_request(MODE_CMD,  32'hABCD_EF5A);
    send_request(MODE_CMD,  32'h0000_0028);
    send_request(MODE_CHAR, 32'd0);
    send_request(MODE_CHAR, 32'd9);
    send_request(MODE_CHAR, 32'd10);
    send_request(MODE_CHAR, 32'h0000_00FF);
    send_request(MODE_CHAR, 32'h1234_5603);
    send_request(MODE_CHAR, 32'hFFFF_FF41);
    send_request(MODE_NUM,  32'd0);
    send_request(MODE_NUM,  32'd1);
    send_request(MODE_NUM,  32'd9);
    send_request(MODE_NUM,  32'd10);
    send_request(MODE_NUM,  32'd99);
    send_request(MODE_NUM,  32'd100);
    send_request(MODE_NUM,  32'd1000000000);
    send_request(MODE_NUM,  32'd4000000000);
    send_request(MODE_NUM,  32'h8000_0000);
    send_request(MODE_NUM,  32'hFFFF_FFFF);
    send_request(MODE_NONE, 32'h0000_0000);
    send_request(MODE_NONE, 32'hFFFF_FFFF);
    in_valid <= 1'b0;

    set_bus_width(1'b0);
    run_random(65, 1'b0);
    set_bus_width(1'b1);
    run_random(70, 1'b1);
    set_bus_width(1'b0);
    run_random(65, 1'b0);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d command, %0d character, %0d number, %0d ignored",
             sb.requests[0] + sb.requests[1] + sb.requests[2] + sb.requests[3],
             sb.requests[MODE_CMD], sb.requests[MODE_CHAR], sb.requests[MODE_NUM],
             sb.requests[MODE_NONE]);
    $display("%0d transfers checked over both bus widths, %0d mismatches, input held %0d cycles",
             sb.checked, sb.mismatches, input_held_cycles);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
